// ===== rtl/cell_accumulation_engine_macros.svh =====
// Assertion macros for the cell accumulation engine.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef CELL_ACCUMULATION_ENGINE_MACROS_SVH
`define CELL_ACCUMULATION_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CAE_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cae: same-cycle check failed");
// Next-cycle implication.
`define CAE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cae: next-cycle check failed");
`else
`define CAE_ASSERT_IMPLY(lbl, ante, cons)
`define CAE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/cae_pkg.sv =====
`timescale 1ns / 1ps
package cae_pkg;

  localparam int CELLS = 4096;
  localparam int IDX_W = $clog2(CELLS);
  localparam int MUL_W = 32;

  localparam int COUNT_W  = 32;
  localparam int WEIGHT_W = 48;
  localparam int DATA_W   = 64;

  localparam logic [2:0] METH_OVERWRITE = 3'd0;
  localparam logic [2:0] METH_MAX       = 3'd1;
  localparam logic [2:0] METH_MIN       = 3'd2;
  localparam logic [2:0] METH_AVG       = 3'd3;
  localparam logic [2:0] METH_WAVG      = 3'd4;
  localparam logic [2:0] METH_MAXW      = 3'd5;
  localparam logic [2:0] METH_RESET     = METH_AVG;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL_K,
    S_MUL_D,
    S_MUL_S,
    S_WRITE
  } cae_state_t;

  typedef struct packed {
    logic        [COUNT_W-1:0]  count;
    logic        [WEIGHT_W-1:0] weight;
    logic signed [DATA_W-1:0]   data;
    logic signed [DATA_W-1:0]   second;
  } cae_entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    cae_entry_t       wr_data;
  } cae_store_req_t;

endpackage

// ===== rtl/cell_accumulation_engine.sv =====
`timescale 1ns / 1ps
`include "cell_accumulation_engine_macros.svh"
// Cell accumulation engine: a store of CELLS cells (count, weight, data,
// second quantity) updated one sample at a time under the method held in
// the configuration register (cfg_we / cfg_wdata, reset to average).
// Input channel: a sample beat is taken at a rising edge with start high
// and busy low. The cell is read, updated and written back, and the new
// contents come out on the out_ ports for one cycle, marked by out_valid.
// The receiver cannot stall: every result is taken in its strobe cycle.
// out_valid is registered from S_WRITE, reached through S_READ, S_MUL_K,
// S_MUL_D and S_MUL_S. The sequencer walks one shared 32x32 multiplier
// through four products (v*v, repeat*weight, k*v, k*v*v), with one store
// read and one store write per sample, and busy holds off a new beat meanwhile.
// Busy is low in the strobe cycle, so the next beat may be accepted there.
// Reset: the method returns to average and a clearing pass zeroes the
// store, one cell a cycle, over all CELLS (4096) cells; busy stays high
// meanwhile. Configuration writes are taken at any time, but the method
// must only change while the block is idle.
module cell_accumulation_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic        [11:0] in_cell_index,
  input  logic signed [15:0] in_sample_value,
  input  logic        [15:0] in_sample_weight,
  input  logic        [7:0]  in_repeat_count,
  output logic               out_valid,
  output logic        [11:0] out_index,
  output logic        [31:0] out_hit_count,
  output logic        [47:0] out_weight_total,
  output logic signed [63:0] out_data_total,
  output logic signed [63:0] out_second_total,
  input  logic               cfg_we,
  input  logic        [2:0]  cfg_wdata
);
  import cae_pkg::*;

  cae_state_t state_r, state_nxt;
  logic [2:0] method_r;

  // latched sample
  logic        [IDX_W-1:0] idx_r;
  logic signed [15:0]      v_r;
  logic        [15:0]      w_r;
  logic        [7:0]       c_r;

  // intermediate results of the sequence
  logic signed [MUL_W-1:0]    vv_r;
  logic signed [MUL_W-1:0]    k_r;
  logic        [COUNT_W-1:0]  cnt1_r;
  logic        [COUNT_W-1:0]  cntc_r;
  logic        [WEIGHT_W-1:0] wsum_r;
  logic signed [DATA_W-1:0]   dsum_r;
  logic signed [DATA_W-1:0]   diff_r;
  logic                       gt_r;
  logic                       lt_r;

  // result registers
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_idx_r;
  cae_entry_t               out_e_r;

  cae_store_req_t            req;
  cae_entry_t                rd_e;
  cae_entry_t                new_e;
  logic                      clr_busy;
  logic                      accept;
  logic                      mul_en;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [2*MUL_W-1:0] product;
  logic signed [DATA_W-1:0]  v64;
  logic signed [MUL_W-1:0]   v32;
  logic signed [DATA_W-1:0]  ssum;

  function automatic logic signed [63:0] sat_add_s64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic [31:0] sat_add_u32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? {32{1'b1}} : s[31:0];
  endfunction

  function automatic logic [47:0] sat_add_u48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? {48{1'b1}} : s[47:0];
  endfunction

  assign busy   = clr_busy || (state_r != S_IDLE);
  assign accept = start && !busy;
  assign v64    = {{48{v_r[15]}}, v_r};
  assign v32    = {{16{v_r[15]}}, v_r};

  cae_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .rd_data  (rd_e),
    .clr_busy (clr_busy)
  );

  cae_mul u_mul (
    .clk     (clk),
    .en      (mul_en),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .product (product)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      method_r    <= METH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_WRITE);
      if (cfg_we) begin
        method_r <= cfg_wdata;
      end
    end
  end

  // sequencer: one store read, four products on the shared multiplier, one write
  always_comb begin
    state_nxt       = state_r;
    mul_en          = 1'b0;
    mul_a           = '0;
    mul_b           = '0;
    req.rd_en       = 1'b0;
    req.rd_addr     = IDX_W'(in_cell_index % CELLS);
    req.wr_en       = 1'b0;
    req.wr_addr     = idx_r;
    req.wr_data     = new_e;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req.rd_en = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // value squared
        mul_en    = 1'b1;
        mul_a     = v32;
        mul_b     = v32;
        state_nxt = S_MUL_K;
      end
      S_MUL_K: begin
        // k = repeat * weight, or repeat alone for the plain average
        mul_en    = 1'b1;
        mul_a     = {24'b0, c_r};
        mul_b     = (method_r == METH_WAVG) ? {16'b0, w_r} : 32'sd1;
        state_nxt = S_MUL_D;
      end
      S_MUL_D: begin
        mul_en    = 1'b1;
        mul_a     = product[MUL_W-1:0];
        mul_b     = v32;
        state_nxt = S_MUL_S;
      end
      S_MUL_S: begin
        mul_en    = 1'b1;
        mul_a     = k_r;
        mul_b     = vv_r;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        req.wr_en = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath registers; the old cell contents hold in the store's read register
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= IDX_W'(in_cell_index % CELLS);
      v_r   <= in_sample_value;
      w_r   <= in_sample_weight;
      c_r   <= in_repeat_count;
    end
    case (state_r)
      S_MUL_K: begin
        vv_r   <= product[MUL_W-1:0];
        cnt1_r <= sat_add_u32(rd_e.count, 32'd1);
        cntc_r <= sat_add_u32(rd_e.count, {24'b0, c_r});
        gt_r   <= v64 > rd_e.data;
        lt_r   <= v64 < rd_e.data;
      end
      S_MUL_D: begin
        k_r    <= product[MUL_W-1:0];
        // average adds repeat times 1.0 in Q16; weighted average adds k
        wsum_r <= sat_add_u48(rd_e.weight, (method_r == METH_WAVG) ?
                              48'(product[23:0]) : {24'b0, c_r, 16'b0});
        diff_r <= sat_add_s64(rd_e.data, -v64);
      end
      S_MUL_S: begin
        dsum_r <= sat_add_s64(rd_e.data, product);
      end
      S_WRITE: begin
        out_idx_r <= idx_r;
        out_e_r   <= new_e;
      end
      default: begin
      end
    endcase
  end

  // updated cell under the configured method
  always_comb begin
    ssum  = sat_add_s64(rd_e.second, product);
    new_e = rd_e;
    case (method_r)
      METH_OVERWRITE: begin
        new_e.count = cnt1_r;
        if (w_r != 16'd0) begin
          if (cnt1_r > 32'd1) begin
            new_e.second = diff_r;
          end
          new_e.data   = v64;
          new_e.weight = {32'b0, w_r};
        end
      end
      METH_MAX: begin
        if (w_r != 16'd0 && (rd_e.weight == '0 || gt_r)) begin
          new_e.data   = v64;
          new_e.weight = {32'b0, w_r};
        end
        new_e.count = cnt1_r;
      end
      METH_MIN: begin
        if (w_r != 16'd0 && (rd_e.weight == '0 || lt_r)) begin
          new_e.data   = v64;
          new_e.weight = {32'b0, w_r};
        end
        new_e.count = 32'd1;
      end
      METH_AVG, METH_WAVG: begin
        new_e.count = cntc_r;
        if (w_r != 16'd0) begin
          new_e.data   = dsum_r;
          new_e.weight = wsum_r;
          new_e.second = ssum;
        end
      end
      METH_MAXW: begin
        if ({32'b0, w_r} >= rd_e.weight) begin
          new_e.data   = v64;
          new_e.weight = {32'b0, w_r};
          new_e.count  = 32'd1;
        end
      end
      default: begin
        // unused codes leave the cell as it is
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_index        = 12'(out_idx_r);
  assign out_hit_count    = out_e_r.count;
  assign out_weight_total = out_e_r.weight;
  assign out_data_total   = out_e_r.data;
  assign out_second_total = out_e_r.second;

  `CAE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `CAE_ASSERT_IMPLY(a_strobe_idle, out_valid, !busy)
  `CAE_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `CAE_ASSERT_NEXT(a_write_strobe, state_r == S_WRITE, out_valid)

endmodule

// ===== rtl/cae_store.sv =====
`timescale 1ns / 1ps
module cae_store (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cae_pkg::cae_store_req_t req,
  output cae_pkg::cae_entry_t     rd_data,
  output logic                    clr_busy
);
  import cae_pkg::*;

  cae_entry_t       mem [CELLS];
  cae_entry_t       rd_data_r;
  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_addr_r;

  // sweep every cell to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == IDX_W'(CELLS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

// ===== rtl/cae_mul.sv =====
`timescale 1ns / 1ps
module cae_mul (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [cae_pkg::MUL_W-1:0]   op_a,
  input  logic signed [cae_pkg::MUL_W-1:0]   op_b,
  output logic signed [2*cae_pkg::MUL_W-1:0] product
);
  import cae_pkg::*;

  logic signed [2*MUL_W-1:0] product_r;

  always_ff @(posedge clk) begin
    if (en) begin
      product_r <= op_a * op_b;
    end
  end

  assign product = product_r;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import cae_pkg::*;

  // Method codes the block leaves unused; a cell under them is only reported.
  localparam logic [2:0] METH_SPARE_6 = 3'd6;
  localparam logic [2:0] METH_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS = 800;
  localparam int PRINT_LIMIT  = 40;

  localparam logic [63:0] INT64_TOP    = {1'b0, {63{1'b1}}};
  localparam logic [63:0] INT64_BOTTOM = {1'b1, {63{1'b0}}};

  // Contents of one cell after a sample beat, as the out_ ports show it.
  typedef struct {
    logic        [11:0] index;
    logic        [31:0] hits;
    logic        [47:0] weight;
    logic signed [63:0] data;
    logic signed [63:0] second;
  } cell_view_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic        [11:0] in_cell_index;
  logic signed [15:0] in_sample_value;
  logic        [15:0] in_sample_weight;
  logic        [7:0]  in_repeat_count;
  logic               out_valid;
  logic        [11:0] out_index;
  logic        [31:0] out_hit_count;
  logic        [47:0] out_weight_total;
  logic signed [63:0] out_data_total;
  logic signed [63:0] out_second_total;
  logic               cfg_we;
  logic        [2:0]  cfg_wdata;

  // Shadow copy of the cell store and the method register.
  logic        [31:0] hits_mem   [CELLS];
  logic        [47:0] weight_mem [CELLS];
  logic signed [63:0] data_mem   [CELLS];
  logic signed [63:0] second_mem [CELLS];
  logic        [2:0]  cur_method;

  // Updated cells waiting for their strobe, oldest first.
  cell_view_t due_cells[$];

  int mismatch_count;
  int burst_left;

  cell_accumulation_engine u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cell_index    (in_cell_index),
    .in_sample_value  (in_sample_value),
    .in_sample_weight (in_sample_weight),
    .in_repeat_count  (in_repeat_count),
    .out_valid        (out_valid),
    .out_index        (out_index),
    .out_hit_count    (out_hit_count),
    .out_weight_total (out_weight_total),
    .out_data_total   (out_data_total),
    .out_second_total (out_second_total),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------
  // Saturating arithmetic of the store
  // ---------------------------------------------------------------------

  // Hit count: clamp at 2^32-1.
  function automatic logic [31:0] add_hits(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  // Weight: clamp at 2^48-1. The addend never exceeds 2^25 here.
  function automatic logic [47:0] add_weight(logic [47:0] a, longint b);
    logic [48:0] s;
    s = {1'b0, a} + b[48:0];
    return s[48] ? '1 : s[47:0];
  endfunction

  // Signed data and second sums: clamp at the int64 limits.
  function automatic logic signed [63:0] add_clamped(logic signed [63:0] a,
                                                     logic signed [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s[64] != s[63]) return s[64] ? INT64_BOTTOM : INT64_TOP;
    return s[63:0];
  endfunction

  // ---------------------------------------------------------------------
  // Cell update under the current method; returns the new cell contents
  // ---------------------------------------------------------------------
  function automatic cell_view_t accumulate_sample(logic [11:0] cell_id,
                                                   logic signed [15:0] val,
                                                   logic [15:0] wt,
                                                   logic [7:0] rep);
    cell_view_t r;
    int unsigned slot;
    longint v_l;
    longint reps;
    longint cw;
    logic better;
    slot = cell_id % CELLS;
    v_l  = val;
    reps = longint'(rep);
    cw   = reps * longint'(wt);
    case (cur_method)
      METH_OVERWRITE: begin
        hits_mem[slot] = add_hits(hits_mem[slot], 1);
        if (wt != 0) begin
          // Keep the difference to the previous value once the cell has history.
          if (hits_mem[slot] > 1) second_mem[slot] = add_clamped(data_mem[slot], -v_l);
          data_mem[slot]   = v_l;
          weight_mem[slot] = 48'(wt);
        end
      end
      METH_MAX, METH_MIN: begin
        better = (cur_method == METH_MAX) ? (v_l > data_mem[slot]) : (v_l < data_mem[slot]);
        if (wt != 0 && (weight_mem[slot] == 0 || better)) begin
          data_mem[slot]   = v_l;
          weight_mem[slot] = 48'(wt);
        end
        if (cur_method == METH_MAX) hits_mem[slot] = add_hits(hits_mem[slot], 1);
        else hits_mem[slot] = 1;
      end
      METH_AVG: begin
        hits_mem[slot] = add_hits(hits_mem[slot], 32'(rep));
        if (wt != 0) begin
          data_mem[slot]   = add_clamped(data_mem[slot], reps * v_l);
          weight_mem[slot] = add_weight(weight_mem[slot], reps * 65536);
          second_mem[slot] = add_clamped(second_mem[slot], reps * v_l * v_l);
        end
      end
      METH_WAVG: begin
        hits_mem[slot] = add_hits(hits_mem[slot], 32'(rep));
        if (wt != 0) begin
          weight_mem[slot] = add_weight(weight_mem[slot], cw);
          data_mem[slot]   = add_clamped(data_mem[slot], cw * v_l);
          second_mem[slot] = add_clamped(second_mem[slot], cw * v_l * v_l);
        end
      end
      METH_MAXW: begin
        if ({32'd0, wt} >= weight_mem[slot]) begin
          data_mem[slot]   = v_l;
          weight_mem[slot] = 48'(wt);
          hits_mem[slot]   = 1;
        end
      end
      default: begin
        // Spare codes: leave the cell as it is.
      end
    endcase
    r.index  = slot[11:0];
    r.hits   = hits_mem[slot];
    r.weight = weight_mem[slot];
    r.data   = data_mem[slot];
    r.second = second_mem[slot];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Mismatch reporting; print the first few, count them all
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("cell %0d %s got %h want %h", out_index, name, got, want));
  endtask

  // Compare each strobed result with the oldest pending cell. Outputs are
  // sampled at the edge that ends the strobe cycle, before they move on.
  always @(posedge clk) begin
    cell_view_t want;
    if (rst_n && out_valid) begin
      if (due_cells.size() == 0) begin
        report_mismatch($sformatf("result for cell %0d with nothing pending", out_index));
      end else begin
        want = due_cells.pop_front();
        check_field("index", 64'(out_index), 64'(want.index));
        check_field("hit_count", 64'(out_hit_count), 64'(want.hits));
        check_field("weight_total", 64'(out_weight_total), 64'(want.weight));
        check_field("data_total", out_data_total, want.data);
        check_field("second_total", out_second_total, want.second);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Drop start and idle for the given number of cycles.
  task automatic rest(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Offer one sample beat and hold it until the block takes it. Start stays
  // high on return, unless the sender's burst pattern inserts a gap, so a
  // following beat can ride the same step.
  task automatic send_sample(logic [11:0] cell_id, logic signed [15:0] val,
                             logic [15:0] wt, logic [7:0] rep);
    start            <= 1'b1;
    in_cell_index    <= cell_id;
    in_sample_value  <= val;
    in_sample_weight <= wt;
    in_repeat_count  <= rep;
    do @(posedge clk); while (busy !== 1'b0);
    due_cells.push_back(accumulate_sample(cell_id, val, wt, rep));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      // Skip the gap now and then so some bursts run back to back.
      if ($urandom_range(0, 3) != 0) rest($urandom_range(1, 8));
    end
  endtask

  // Stop sending and hold until every pending cell has come back.
  task automatic settle();
    rest(1);
    while (due_cells.size() != 0) @(posedge clk);
  endtask

  // Change the method only while the block is idle.
  task automatic write_method(logic [2:0] code);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cur_method = code;
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------

  // Average is the method after reset: run it without a write first.
  task automatic test_average_sums();
    send_sample(12'd0, -16'sd32768, 16'hFFFF, 8'd255);
    send_sample(12'd0, 16'sd32767, 16'd1, 8'd1);
    // Undetected sample: count grows, sums hold.
    send_sample(12'd4095, 16'sd100, 16'd0, 8'd10);
    // Zero repeat count adds nothing.
    send_sample(12'd4095, 16'sd200, 16'd5, 8'd0);
  endtask

  task automatic test_weighted_sums();
    write_method(METH_WAVG);
    send_sample(12'd4095, 16'sd32767, 16'hFFFF, 8'd255);
    send_sample(12'd4095, -16'sd1, 16'h8000, 8'd0);
    send_sample(12'd1, -16'sd32768, 16'hFFFF, 8'd255);
  endtask

  task automatic test_overwrite();
    write_method(METH_OVERWRITE);
    // Cell 0 carries large sums: the difference starts from them.
    send_sample(12'd0, 16'sd32767, 16'd1, 8'd200);
    send_sample(12'd2, 16'sd77, 16'd0, 8'd1);
    send_sample(12'd2, -16'sd5, 16'd100, 8'd1);
    // First hit on a fresh cell keeps no difference.
    send_sample(12'd3, 16'sd3, 16'd7, 8'd9);
  endtask

  task automatic test_extremum_select();
    write_method(METH_MAX);
    send_sample(12'd5, -16'sd100, 16'd0, 8'd1);
    // Empty weight: the first detected value is taken even though it is low.
    send_sample(12'd5, -16'sd100, 16'd3, 8'd1);
    send_sample(12'd5, -16'sd200, 16'd9, 8'd4);
    send_sample(12'd5, 16'sd50, 16'd1, 8'd1);
    write_method(METH_MIN);
    send_sample(12'd5, 16'sd60, 16'd2, 8'd1);
    send_sample(12'd5, -16'sd32768, 16'hFFFF, 8'd255);
    send_sample(12'd6, 16'sd1, 16'd0, 8'd1);
  endtask

  task automatic test_max_weight();
    write_method(METH_MAXW);
    send_sample(12'd7, 16'sd10, 16'd0, 8'd1);
    // Equal weight still replaces.
    send_sample(12'd7, 16'sd20, 16'd0, 8'd1);
    send_sample(12'd7, 16'sd30, 16'd500, 8'd1);
    send_sample(12'd7, 16'sd40, 16'd499, 8'd1);
  endtask

  task automatic test_spare_methods();
    write_method(METH_SPARE_6);
    send_sample(12'd0, 16'sd1234, 16'd42, 8'd3);
    write_method(METH_SPARE_7);
    send_sample(12'd4095, -16'sd1234, 16'hFFFF, 8'd255);
  endtask

  // ---------------------------------------------------------------------
  // Random phases: one method each, most beats on a small set of hot cells
  // so that sums build up and repeated cells read back their own updates.
  // ---------------------------------------------------------------------
  task automatic test_random_mix();
    int done;
    int phase_items;
    logic [2:0] code;
    logic [11:0] cell_id;
    logic signed [15:0] val;
    logic [15:0] wt;
    logic [7:0] rep;
    int pick;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      case ($urandom_range(0, 13))
        0, 1:    code = METH_OVERWRITE;
        2, 3:    code = METH_MAX;
        4, 5:    code = METH_MIN;
        6, 7:    code = METH_AVG;
        8, 9:    code = METH_WAVG;
        10, 11:  code = METH_MAXW;
        12:      code = METH_SPARE_6;
        default: code = METH_SPARE_7;
      endcase
      write_method(code);
      phase_items = $urandom_range(20, 90);
      repeat (phase_items) begin
        if ($urandom_range(0, 3) == 0) begin
          cell_id = 12'($urandom_range(0, CELLS - 1));
        end else begin
          // Hot cells at both ends of the index range.
          pick = $urandom_range(0, 15);
          cell_id = (pick < 8) ? 12'(pick) : 12'(4080 + pick);
        end
        case ($urandom_range(0, 7))
          0:       val = -16'sd32768;
          1:       val = 16'sd32767;
          2:       val = 16'(int'($urandom_range(0, 63)) - 32);
          default: val = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
          0:       wt = 16'd0;
          1:       wt = 16'hFFFF;
          2:       wt = 16'($urandom_range(1, 8));
          default: wt = 16'($urandom);
        endcase
        case ($urandom_range(0, 15))
          0:       rep = 8'd0;
          1:       rep = 8'd255;
          2:       rep = 8'd1;
          default: rep = 8'($urandom_range(1, 255));
        endcase
        send_sample(cell_id, val, wt, rep);
        done++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_cell_index    <= '0;
    in_sample_value  <= '0;
    in_sample_weight <= '0;
    in_repeat_count  <= '0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    mismatch_count = 0;
    burst_left     = 1;
    cur_method     = METH_RESET;
    for (int i = 0; i < CELLS; i++) begin
      hits_mem[i]   = '0;
      weight_mem[i] = '0;
      data_mem[i]   = '0;
      second_mem[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The clearing pass after reset shows up as busy; the first beat waits on it.
    test_average_sums();
    test_weighted_sums();
    test_overwrite();
    test_extremum_select();
    test_max_weight();
    test_spare_methods();
    test_random_mix();

    // Wait out what is pending, then give the block a few more cycles to
    // show any stray strobe.
    settle();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cae_pkg.sv
rtl/cae_store.sv
rtl/cae_mul.sv
rtl/cell_accumulation_engine.sv
sim/testbench.sv
